### hw/rtl/efv_pkg.sv
// shared widths, constants, cell payload type and saturation helpers for the flux pipeline
package efv_pkg;

    localparam int DATA_W     = 48;
    localparam int MAG_W      = 49;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int DEN_W      = 47;
    localparam int TAG_W      = 8;
    localparam int GAMMA_W    = 18;
    localparam int GAMMA_FRAC = 16;
    localparam int IN_W       = 2 * TAG_W + 4 * DATA_W;
    localparam int OUT_W      = 2 * TAG_W + 8 * DATA_W;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd26214;
    localparam logic               REG_GAMMA   = 1'b0;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [TAG_W-1:0]  row;
        logic [TAG_W-1:0]  col;
        logic              fault;
        logic [DEN_W-1:0]  den;
        logic [DATA_W-1:0] mx;
        logic [DATA_W-1:0] my;
        logic [DATA_W-1:0] en;
    } cell_t;

    // signed result from a magnitude, an overflow mark and a sign
    function automatic logic [DATA_W-1:0] sat_mag(input logic [DATA_W-1:0] q,
                                                  input logic ovf, input logic neg);
        logic big;
        big = ovf | q[DATA_W-1];
        if (neg) begin
            return big ? SAT_MIN : (~q + 1'b1);
        end
        return big ? SAT_MAX : q;
    endfunction

    // clamp a one-bit-wider signed sum
    function automatic logic [DATA_W-1:0] sat_sum(input logic [DATA_W:0] x);
        if (x[DATA_W] != x[DATA_W-1]) begin
            return x[DATA_W] ? SAT_MIN : SAT_MAX;
        end
        return x[DATA_W-1:0];
    endfunction

    // magnitude of a signed word, one bit wider
    function automatic logic [MAG_W-1:0] mag(input logic [DATA_W-1:0] x);
        logic [MAG_W-1:0] e;
        e = {x[DATA_W-1], x};
        return x[DATA_W-1] ? (~e + 1'b1) : e;
    endfunction

endpackage

### hw/rtl/efv_mul.sv
// two-stage unsigned multiplier lanes built from half-width partial products
module efv_mul #(
    parameter int W     = efv_pkg::MAG_W,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [LANES-1:0][W-1:0]       in_a,
    input  logic [LANES-1:0][W-1:0]       in_b,
    input  logic [SW-1:0]                 in_side,
    output logic                          out_valid,
    output logic [LANES-1:0][2*W-1:0]     out_p,
    output logic [SW-1:0]                 out_side
);

    localparam int LW = W / 2;
    localparam int HW = W - LW;

    logic                           v1_reg;
    logic                           v2_reg;
    logic [SW-1:0]                  side1_reg;
    logic [SW-1:0]                  side2_reg;
    logic [LANES-1:0][2*LW-1:0]     ll_reg;
    logic [LANES-1:0][LW+HW-1:0]    lh_reg;
    logic [LANES-1:0][LW+HW-1:0]    hl_reg;
    logic [LANES-1:0][2*HW-1:0]     hh_reg;
    logic [LANES-1:0][2*W-1:0]      p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= in_side;
            side2_reg <= side1_reg;
            for (int i = 0; i < LANES; i++) begin
                ll_reg[i] <= (2*LW)'(in_a[i][LW-1:0]) * (2*LW)'(in_b[i][LW-1:0]);
                lh_reg[i] <= (LW+HW)'(in_a[i][LW-1:0]) * (LW+HW)'(in_b[i][W-1:LW]);
                hl_reg[i] <= (LW+HW)'(in_a[i][W-1:LW]) * (LW+HW)'(in_b[i][LW-1:0]);
                hh_reg[i] <= (2*HW)'(in_a[i][W-1:LW]) * (2*HW)'(in_b[i][W-1:LW]);
                p_reg[i]  <= (2*W)'(ll_reg[i])
                           + ((2*W)'(lh_reg[i]) << LW)
                           + ((2*W)'(hl_reg[i]) << LW)
                           + ((2*W)'(hh_reg[i]) << (2*LW));
            end
        end
    end

    assign out_valid = v2_reg;
    assign out_p     = p_reg;
    assign out_side  = side2_reg;

endmodule

### hw/rtl/efv_div.sv
// pipelined restoring divider, one quotient bit per stage, shared divisor across lanes
module efv_div #(
    parameter int NW    = 96,
    parameter int QW    = efv_pkg::DATA_W,
    parameter int DW    = efv_pkg::DEN_W,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [LANES-1:0][NW-1:0]   in_n,
    input  logic [DW-1:0]              in_d,
    input  logic [SW-1:0]              in_side,
    output logic                       out_valid,
    output logic [LANES-1:0][QW-1:0]   out_q,
    output logic [LANES-1:0]           out_ovf,
    output logic [SW-1:0]              out_side
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW + 1) ? HW : DW + 1;

    logic [QW:0]                 v_reg;
    logic [SW-1:0]               side_reg [0:QW];
    logic [DW-1:0]               d_reg    [0:QW];
    logic [LANES-1:0][DW-1:0]    rem_reg  [0:QW];
    logic [LANES-1:0][QW-1:0]    low_reg  [0:QW];
    logic [LANES-1:0][QW-1:0]    q_reg    [0:QW];
    logic [LANES-1:0]            ovf_reg  [0:QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[QW-1:0], in_valid};
        end
    end

    // quotient of 2^QW or more is flagged up front, so the remainder starts below the divisor
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            d_reg[0]    <= in_d;
            for (int i = 0; i < LANES; i++) begin
                rem_reg[0][i] <= DW'(in_n[i][NW-1:QW]);
                low_reg[0][i] <= in_n[i][QW-1:0];
                q_reg[0][i]   <= '0;
                ovf_reg[0][i] <= CW'(in_n[i][NW-1:QW]) >= CW'(in_d);
            end
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++) begin : g_step
            logic [LANES-1:0][DW:0] t;
            logic [LANES-1:0][DW:0] diff;
            logic [LANES-1:0]       ge;

            always_comb begin
                for (int i = 0; i < LANES; i++) begin
                    t[i]    = {rem_reg[k-1][i], low_reg[k-1][i][QW-1]};
                    diff[i] = t[i] - {1'b0, d_reg[k-1]};
                    ge[i]   = t[i] >= {1'b0, d_reg[k-1]};
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[k] <= side_reg[k-1];
                    d_reg[k]    <= d_reg[k-1];
                    ovf_reg[k]  <= ovf_reg[k-1];
                    for (int i = 0; i < LANES; i++) begin
                        rem_reg[k][i] <= ge[i] ? diff[i][DW-1:0] : t[i][DW-1:0];
                        q_reg[k][i]   <= {q_reg[k-1][i][QW-2:0], ge[i]};
                        low_reg[k][i] <= low_reg[k-1][i] << 1;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[QW];
    assign out_q     = q_reg[QW];
    assign out_ovf   = ovf_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

### hw/rtl/euler_flux_vectors.sv
// top level: 2-d euler x and y flux vectors for one grid cell per transfer
//
// s_ channel: one cell per transfer (row and column tag, density, momenta, energy,
//   all Q31.16). m_ channel: the tag, eight saturated fluxes, and the density fault
//   flag on m_tuser; fluxes are zero when density is zero or negative.
// apb port: register 0 at byte address 0 is gamma_minus_one (unsigned Q2.16);
//   write it only while no cell is in flight.
// depth: 114 register stages from the input capture to m_tvalid. throughput: one
//   cell per cycle while the pipeline is not held by a stall (see below); the depth
//   comes from the two 49-stage dividers, one quotient bit per stage (kinetic energy
//   and the momentum terms, then the energy terms, which need pressure first), and
//   the three two-stage multipliers, one ahead of the first divider and two between.
// reset: all stage valid bits clear, the register returns to 0.4, no output is valid.
// stall: while a result waits on m_tready the pipeline keeps moving as long as its
//   last stage is empty, so bubbles get squeezed out; with the last stage full
//   the whole pipeline holds and s_tready drops. nothing is lost or repeated.
module euler_flux_vectors (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // cell_row, cell_col, density, momentum_x, momentum_y, total_energy
    input  logic [efv_pkg::IN_W-1:0]     s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_row, out_col, xflux_mass, xflux_momx, xflux_momy, xflux_energy,
    // yflux_mass, yflux_momx, yflux_momy, yflux_energy
    output logic [efv_pkg::OUT_W-1:0]    m_tdata,
    // density_fault
    output logic [0:0]                   m_tuser,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [efv_pkg::APB_AW-1:0]   paddr,
    input  logic [efv_pkg::APB_DW-1:0]   pwdata,
    output logic [efv_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int DW = efv_pkg::DATA_W;
    localparam int MW = efv_pkg::MAG_W;
    localparam int PW = efv_pkg::PROD_W;
    localparam int TW = efv_pkg::TAG_W;
    localparam int GW = efv_pkg::GAMMA_W;
    localparam int GF = efv_pkg::GAMMA_FRAC;

    typedef struct packed {
        efv_pkg::cell_t  item;
        logic [DW-1:0]   rxx;
        logic [DW-1:0]   ryy;
        logic [DW-1:0]   rxy;
        logic            neg;
    } mid_side_t;

    // config register
    logic [GW-1:0] gamma_reg;
    logic          cfg_wr;

    assign cfg_wr = psel & penable & pwrite & (paddr[2] == efv_pkg::REG_GAMMA);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == efv_pkg::REG_GAMMA) ? efv_pkg::APB_DW'(gamma_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg <= efv_pkg::GAMMA_RESET;
        end else if (cfg_wr) begin
            gamma_reg <= pwdata[GW-1:0];
        end
    end

    // pipeline control
    logic pipe_en;
    logic out_free;
    logic d2_valid;
    logic m_valid_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign pipe_en  = out_free || !d2_valid;
    assign s_tready = pipe_en;

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;

    // stage payloads
    efv_pkg::cell_t             c0_reg, c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    logic [DW-1:0]              rho0_reg;
    logic [MW-1:0]              amx1_reg, amy1_reg;
    logic [3:0][95:0]           n2_reg;
    logic [DW-1:0]              ke3_reg, rxx3_reg, ryy3_reg, rxy3_reg;
    logic [DW-1:0]              rxx4_reg, ryy4_reg, rxy4_reg, rxx5_reg, ryy5_reg, rxy5_reg;
    logic [DW:0]                ediff4_reg;
    logic [MW-1:0]              emag5_reg;
    logic                       eneg5_reg;
    mid_side_t                  ms6_reg, ms7_reg, ms8_reg;
    logic [DW-1:0]              p6_reg;
    logic [DW:0]                ep7_reg;
    logic [MW-1:0]              epmag8_reg, amx8_reg, amy8_reg;

    logic [2:0][MW-1:0]         m1_a, m1_b;
    logic [2:0][PW-1:0]         m1_p;
    logic                       m1_valid;
    efv_pkg::cell_t             m1_side;

    logic [3:0][DW-1:0]         d1_q;
    logic [3:0]                 d1_ovf;
    logic                       d1_valid;
    efv_pkg::cell_t             d1_side;

    logic [0:0][MW-1:0]         m2_a, m2_b;
    logic [0:0][PW-1:0]         m2_p;
    logic                       m2_valid;
    mid_side_t                  m2_in_side, m2_side;

    logic [1:0][MW-1:0]         m3_a, m3_b;
    logic [1:0][PW-1:0]         m3_p;
    logic                       m3_valid;
    mid_side_t                  m3_side;

    logic [1:0][DW-1:0]         d2_q;
    logic [1:0]                 d2_ovf;
    mid_side_t                  d2_side;

    logic [efv_pkg::OUT_W-1:0]  m_data_reg;
    logic                       m_fault_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (pipe_en) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= m1_valid;
            v3_reg <= d1_valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= m2_valid;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    // input capture through magnitudes, sums of squares, pressure and the energy term
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            c0_reg.row   <= s_tdata[TW-1:0];
            c0_reg.col   <= s_tdata[2*TW-1:TW];
            c0_reg.fault <= 1'b0;
            c0_reg.den   <= s_tdata[2*TW+efv_pkg::DEN_W-1:2*TW];
            rho0_reg     <= s_tdata[2*TW+DW-1:2*TW];
            c0_reg.mx    <= s_tdata[2*TW+2*DW-1:2*TW+DW];
            c0_reg.my    <= s_tdata[2*TW+3*DW-1:2*TW+2*DW];
            c0_reg.en    <= s_tdata[2*TW+4*DW-1:2*TW+3*DW];

            c1_reg       <= {c0_reg.row, c0_reg.col, rho0_reg[DW-1] | (rho0_reg == '0),
                             c0_reg.den, c0_reg.mx, c0_reg.my, c0_reg.en};
            amx1_reg     <= efv_pkg::mag(c0_reg.mx);
            amy1_reg     <= efv_pkg::mag(c0_reg.my);

            // kinetic numerator is half the sum of squares, divided by rho later
            c2_reg    <= m1_side;
            n2_reg[0] <= 96'(((PW+1)'(m1_p[0]) + (PW+1)'(m1_p[1])) >> 1);
            n2_reg[1] <= 96'(m1_p[0]);
            n2_reg[2] <= 96'(m1_p[1]);
            n2_reg[3] <= 96'(m1_p[2]);

            c3_reg   <= d1_side;
            ke3_reg  <= efv_pkg::sat_mag(d1_q[0], d1_ovf[0], 1'b0);
            rxx3_reg <= efv_pkg::sat_mag(d1_q[1], d1_ovf[1], 1'b0);
            ryy3_reg <= efv_pkg::sat_mag(d1_q[2], d1_ovf[2], 1'b0);
            rxy3_reg <= efv_pkg::sat_mag(d1_q[3], d1_ovf[3],
                                         d1_side.mx[DW-1] ^ d1_side.my[DW-1]);

            c4_reg     <= c3_reg;
            ediff4_reg <= {c3_reg.en[DW-1], c3_reg.en} - {ke3_reg[DW-1], ke3_reg};
            rxx4_reg   <= rxx3_reg;
            ryy4_reg   <= ryy3_reg;
            rxy4_reg   <= rxy3_reg;

            c5_reg    <= c4_reg;
            eneg5_reg <= ediff4_reg[DW];
            emag5_reg <= ediff4_reg[DW] ? (~ediff4_reg + 1'b1) : ediff4_reg;
            rxx5_reg  <= rxx4_reg;
            ryy5_reg  <= ryy4_reg;
            rxy5_reg  <= rxy4_reg;

            // pressure: product shifted down by the gamma fraction, sign from energy minus ke
            ms6_reg <= m2_side;
            p6_reg  <= efv_pkg::sat_mag(m2_p[0][GF+DW-1:GF], |m2_p[0][PW-1:GF+DW],
                                        m2_side.neg);

            ep7_reg     <= {ms6_reg.item.en[DW-1], ms6_reg.item.en} + {p6_reg[DW-1], p6_reg};
            ms7_reg     <= {ms6_reg.item,
                            efv_pkg::sat_sum({ms6_reg.rxx[DW-1], ms6_reg.rxx}
                                             + {p6_reg[DW-1], p6_reg}),
                            efv_pkg::sat_sum({ms6_reg.ryy[DW-1], ms6_reg.ryy}
                                             + {p6_reg[DW-1], p6_reg}),
                            ms6_reg.rxy, ms6_reg.neg};

            ms8_reg     <= {ms7_reg.item, ms7_reg.rxx, ms7_reg.ryy, ms7_reg.rxy,
                            ep7_reg[DW]};
            epmag8_reg  <= ep7_reg[DW] ? (~ep7_reg + 1'b1) : ep7_reg;
            amx8_reg    <= efv_pkg::mag(ms7_reg.item.mx);
            amy8_reg    <= efv_pkg::mag(ms7_reg.item.my);
        end
    end

    assign m1_a[0] = amx1_reg;
    assign m1_b[0] = amx1_reg;
    assign m1_a[1] = amy1_reg;
    assign m1_b[1] = amy1_reg;
    assign m1_a[2] = amx1_reg;
    assign m1_b[2] = amy1_reg;

    efv_mul #(.W(MW), .LANES(3), .SW($bits(efv_pkg::cell_t))) u_mul_sq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (v1_reg),
        .in_a      (m1_a),
        .in_b      (m1_b),
        .in_side   (c1_reg),
        .out_valid (m1_valid),
        .out_p     (m1_p),
        .out_side  (m1_side)
    );

    efv_div #(.NW(96), .QW(DW), .DW(efv_pkg::DEN_W), .LANES(4),
              .SW($bits(efv_pkg::cell_t))) u_div_mom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (v2_reg),
        .in_n      (n2_reg),
        .in_d      (c2_reg.den),
        .in_side   (c2_reg),
        .out_valid (d1_valid),
        .out_q     (d1_q),
        .out_ovf   (d1_ovf),
        .out_side  (d1_side)
    );

    assign m2_a[0]         = emag5_reg;
    assign m2_b[0]         = MW'(gamma_reg);
    assign m2_in_side.item = c5_reg;
    assign m2_in_side.rxx  = rxx5_reg;
    assign m2_in_side.ryy  = ryy5_reg;
    assign m2_in_side.rxy  = rxy5_reg;
    assign m2_in_side.neg  = eneg5_reg;

    efv_mul #(.W(MW), .LANES(1), .SW($bits(mid_side_t))) u_mul_prs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (v5_reg),
        .in_a      (m2_a),
        .in_b      (m2_b),
        .in_side   (m2_in_side),
        .out_valid (m2_valid),
        .out_p     (m2_p),
        .out_side  (m2_side)
    );

    assign m3_a[0] = epmag8_reg;
    assign m3_b[0] = amx8_reg;
    assign m3_a[1] = epmag8_reg;
    assign m3_b[1] = amy8_reg;

    efv_mul #(.W(MW), .LANES(2), .SW($bits(mid_side_t))) u_mul_nrg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (v8_reg),
        .in_a      (m3_a),
        .in_b      (m3_b),
        .in_side   (ms8_reg),
        .out_valid (m3_valid),
        .out_p     (m3_p),
        .out_side  (m3_side)
    );

    efv_div #(.NW(PW), .QW(DW), .DW(efv_pkg::DEN_W), .LANES(2),
              .SW($bits(mid_side_t))) u_div_nrg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (m3_valid),
        .in_n      (m3_p),
        .in_d      (m3_side.item.den),
        .in_side   (m3_side),
        .out_valid (d2_valid),
        .out_q     (d2_q),
        .out_ovf   (d2_ovf),
        .out_side  (d2_side)
    );

    // final assembly, fluxes zeroed on a density fault (tags kept)
    logic [DW-1:0] xen, yen;
    logic [efv_pkg::OUT_W-1:0] out_data;

    always_comb begin
        xen = efv_pkg::sat_mag(d2_q[0], d2_ovf[0], d2_side.neg ^ d2_side.item.mx[DW-1]);
        yen = efv_pkg::sat_mag(d2_q[1], d2_ovf[1], d2_side.neg ^ d2_side.item.my[DW-1]);
        out_data[TW-1:0]    = d2_side.item.row;
        out_data[2*TW-1:TW] = d2_side.item.col;
        if (d2_side.item.fault) begin
            out_data[efv_pkg::OUT_W-1:2*TW] = '0;
        end else begin
            out_data[2*TW+DW-1:2*TW]        = d2_side.item.mx;
            out_data[2*TW+2*DW-1:2*TW+DW]   = d2_side.rxx;
            out_data[2*TW+3*DW-1:2*TW+2*DW] = d2_side.rxy;
            out_data[2*TW+4*DW-1:2*TW+3*DW] = xen;
            out_data[2*TW+5*DW-1:2*TW+4*DW] = d2_side.item.my;
            out_data[2*TW+6*DW-1:2*TW+5*DW] = d2_side.rxy;
            out_data[2*TW+7*DW-1:2*TW+6*DW] = d2_side.ryy;
            out_data[2*TW+8*DW-1:2*TW+7*DW] = yen;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && d2_valid) begin
            m_data_reg  <= out_data;
            m_fault_reg <= d2_side.item.fault;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_fault_reg;

endmodule

### dv/tb_euler_flux_vectors.sv
// testbench for the euler flux pipeline: random and corner cells checked against a predictor
`timescale 1ns / 1ps

module tb_euler_flux_vectors;

    localparam logic signed [63:0] LIM_HI = 64'sh7FFF_FFFF_FFFF;
    localparam logic signed [63:0] LIM_LO = -64'sh8000_0000_0000;
    localparam int LATENCY = 113;

    typedef struct {
        logic [7:0]  row;
        logic [7:0]  col;
        logic [47:0] flux [8];
        logic        fault;
    } flux_set_t;

    class flux_scoreboard;
        flux_set_t pending[$];
        int        mismatches;
        logic [17:0] gamma;

        function new();
            mismatches = 0;
            gamma = efv_pkg::GAMMA_RESET;
        endfunction

        // trunc(a*b/d) toward zero, clamped to 48 bits
        function logic signed [63:0] muldiv(logic signed [63:0] a, logic signed [63:0] b,
                                            logic [63:0] d);
            logic [127:0] ma, mb, q;
            logic neg;
            neg = (a < 0) != (b < 0);
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            q = (ma * mb) / d;
            if (neg) return (q > 128'h8000_0000_0000) ? LIM_LO : -$signed({1'b0, q[62:0]});
            return (q > 128'h7FFF_FFFF_FFFF) ? LIM_HI : $signed({1'b0, q[62:0]});
        endfunction

        function logic signed [63:0] clamp(logic signed [63:0] v);
            if (v > LIM_HI) return LIM_HI;
            if (v < LIM_LO) return LIM_LO;
            return v;
        endfunction

        function void note_cell(logic [efv_pkg::IN_W-1:0] d);
            flux_set_t e;
            logic signed [63:0] rho, mx, my, en, ke, p, mxy, ep;
            logic [127:0] sq, kq;
            rho = $signed(d[63:16]);
            mx = $signed(d[111:64]);
            my = $signed(d[159:112]);
            en = $signed(d[207:160]);
            e.row = d[7:0];
            e.col = d[15:8];
            e.fault = rho <= 0;
            foreach (e.flux[k]) e.flux[k] = '0;
            if (!e.fault) begin
                sq = (mx * mx) + (my * my);
                kq = sq / (2 * rho);
                ke = (kq > 128'h7FFF_FFFF_FFFF) ? LIM_HI : $signed({1'b0, kq[62:0]});
                p = muldiv(en - ke, {46'd0, gamma}, 64'd65536);
                mxy = muldiv(mx, my, rho);
                ep = en + p;
                e.flux[0] = mx[47:0];
                e.flux[1] = 48'(clamp(muldiv(mx, mx, rho) + p));
                e.flux[2] = mxy[47:0];
                e.flux[3] = 48'(muldiv(ep, mx, rho));
                e.flux[4] = my[47:0];
                e.flux[5] = mxy[47:0];
                e.flux[6] = 48'(clamp(muldiv(my, my, rho) + p));
                e.flux[7] = 48'(muldiv(ep, my, rho));
            end
            pending = {pending, e};
        endfunction

        function void check_result(logic [efv_pkg::OUT_W-1:0] d, logic u);
            flux_set_t e;
            bit bad;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer %h", d);
                return;
            end
            e = pending.pop_front();
            bad = (d[7:0] != e.row) || (d[15:8] != e.col) || (u != e.fault);
            for (int k = 0; k < 8; k++) if (d[16 + 48*k +: 48] != e.flux[k]) bad = 1;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: tag %0d,%0d fault exp %b got %b",
                             e.row, e.col, e.fault, u);
                    for (int k = 0; k < 8; k++)
                        $display("  flux %0d exp %h got %h", k, e.flux[k], d[16 + 48*k +: 48]);
                    $display("  tag got %0d,%0d", d[7:0], d[15:8]);
                end
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0, s_tready;
    logic [efv_pkg::IN_W-1:0] s_tdata = '0;
    logic m_tvalid, m_tready = 0;
    logic [efv_pkg::OUT_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [efv_pkg::APB_AW-1:0] paddr = '0;
    logic [efv_pkg::APB_DW-1:0] pwdata = '0, prdata;
    logic pready;
    bit   stall_on = 1;
    flux_scoreboard sb = new();

    euler_flux_vectors dut (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // result side: random backpressure, each stall held for a drawn length
    initial begin
        int g;
        g = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
            if (g > 0) g--;
            else g = stall_on ? gap_len() : 0;
            m_tready <= (g == 0);
        end
    end

    task automatic write_gamma(logic [17:0] v);
        psel <= 1; pwrite <= 1; paddr <= {efv_pkg::REG_GAMMA, 2'b00}; pwdata <= {14'd0, v};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.gamma = v;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic send_cell(logic [efv_pkg::IN_W-1:0] d, bit with_gaps);
        int g;
        g = with_gaps ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_cell(d);
    endtask

    function logic [47:0] rand_val(int kind);
        case (kind)
            0: return 48'({$urandom, $urandom});
            1: return 48'(signed'($urandom_range(0, 2000000)) - 1000000);
            2: return 48'h7FFF_FFFF_FFFF;
            3: return 48'h8000_0000_0000;
            default: return 48'(signed'($urandom_range(0, 400000000)) - 200000000);
        endcase
    endfunction

    function logic [efv_pkg::IN_W-1:0] rand_cell();
        logic [47:0] rho;
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) rho = 48'($urandom_range(1, 2000000));
        else if (r < 8) rho = rand_val(0);
        else rho = rand_val($urandom_range(1, 3));
        return {rand_val($urandom_range(0, 4)), rand_val($urandom_range(0, 4)),
                rand_val($urandom_range(0, 4)), rho, 8'($urandom), 8'($urandom)};
    endfunction

    task automatic run_cells(int n, bit with_gaps);
        for (int i = 0; i < n; i++) send_cell(rand_cell(), with_gaps);
        s_tvalid <= 0;
    endtask

    initial begin
        logic [47:0] ex [5];
        ex = '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h0,
               48'h1, 48'hFFFF_FFFF_FFFF};
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // corner cells: extreme fields, zero and negative density, all-ones tag
        for (int i = 0; i < 5; i++)
            send_cell({ex[(i+3)%5], ex[(i+2)%5], ex[(i+1)%5], ex[i], 8'hFF, 8'h00}, 1);
        send_cell({48'd65536, 48'd65536, 48'd65536, 48'd65536, 8'h00, 8'hFF}, 1);
        send_cell({48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'd1,
                   8'hA5, 8'h5A}, 1);
        send_cell({48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'd0, 48'd3, 8'h12, 8'h34}, 1);
        run_cells(12, 1);
        // hold off until the pipeline is empty
        wait_drained();
        run_cells(150, 0);
        stall_on = 0;
        run_cells(100, 0);
        stall_on = 1;
        wait_drained();
        write_gamma(18'd0);
        run_cells(150, 1);
        wait_drained();
        write_gamma(18'h3FFFF);
        run_cells(150, 1);
        wait_drained();
        write_gamma(18'd131072);
        run_cells(150, 1);
        wait_drained();
        write_gamma(18'($urandom));
        run_cells(150, 1);
        wait_drained();
        write_gamma(efv_pkg::GAMMA_RESET);
        run_cells(150, 1);
        wait_drained();
        if (sb.mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
